@@ design/alsm_pkg.sv @@
// Shared types, character codes and helpers for the assembly lexer state machine.
package alsm_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int REPORT_BITS = 16;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    typedef enum logic [3:0] {
        LS_NIL = 4'd0,
        LS_CMT = 4'd1,
        LS_ERR = 4'd2,
        LS_IDN = 4'd3,
        LS_RGT = 4'd4,
        LS_REG = 4'd5,
        LS_SEP = 4'd6,
        LS_IMT = 4'd7,
        LS_IMM = 4'd8,
        LS_LBT = 4'd9,
        LS_LBL = 4'd10,
        LS_ZER = 4'd11,
        LS_ADT = 4'd12,
        LS_ADR = 4'd13
    } t_lex_state;

    typedef enum logic [2:0] {
        ER_NONE = 3'd0,
        ER_IDN  = 3'd1,
        ER_IMM  = 3'd2,
        ER_LBL  = 3'd3,
        ER_ADR  = 3'd4,
        ER_UNK  = 3'd5
    } t_err_code;

    typedef enum logic [3:0] {
        CC_NL,
        CC_SEMI,
        CC_WS,
        CC_R,
        CC_AT,
        CC_HASH,
        CC_UNDER,
        CC_ZERO,
        CC_DIGIT,
        CC_X,
        CC_HEX,
        CC_ALPHA,
        CC_UNK
    } t_char_class;

    typedef struct packed {
        t_char_class             cls;
        logic [REPORT_BITS-1:0]  line;
        logic [REPORT_BITS-1:0]  col;
    } t_front_beat;

    typedef struct packed {
        t_lex_state              state;
        t_err_code               err;
        logic [REPORT_BITS-1:0]  line;
        logic [REPORT_BITS-1:0]  col;
    } t_result;

    function automatic logic [REPORT_BITS-1:0] f_clip(input logic [31:0] v);
        logic [31:0] top;
        top = 32'((64'd1 << REPORT_BITS) - 64'd1);
        return (v > top) ? REPORT_BITS'(top) : v[REPORT_BITS-1:0];
    endfunction

endpackage

@@ design/assembly_lexer_state_machine_core.sv @@
// Top level of the assembly lexer state machine: front, beat queue and back.
//
//  channel   handshake        beat fields
//  input     push / full      i_char_in
//  result    empty / pop      o_lex_state, o_error_code, o_line_number, o_column_number
//
// One character per cycle sustained while full stays low; a result passes through
// the beat queue, then the result queue, before it is on the result ports.
// Synchronous active-low reset: state nil, line and column zero, queues empty.
// Result stalls fill the two-entry result queue, then the two-entry beat queue,
// after which full rises.
module assembly_lexer_state_machine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_lex_state,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number
);
    import alsm_pkg::*;

    logic        w_wr;
    t_front_beat w_fbeat;
    t_front_beat w_qbeat;
    logic        w_q_empty;
    logic        w_take;
    t_result     w_res;

    alsm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_char_in (i_char_in),
        .i_full    (full),
        .o_wr      (w_wr),
        .o_beat    (w_fbeat)
    );

    alsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_fbeat),
        .o_full  (full),
        .i_rd    (w_take),
        .o_data  (w_qbeat),
        .o_empty (w_q_empty)
    );

    alsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_q_empty),
        .i_beat   (w_qbeat),
        .o_take   (w_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (w_res)
    );

    assign o_lex_state     = w_res.state;
    assign o_error_code    = w_res.err;
    assign o_line_number   = w_res.line;
    assign o_column_number = w_res.col;

`ifndef SYNTHESIS
    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("beat queue full while result queue empty");

    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ER_NONE) |-> o_lex_state == LS_ERR)
        else $error("error code without error state");

    a_no_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_lex_state != LS_SEP)
        else $error("separator state entered");

    a_take_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_q_empty)
        else $error("back took a beat from an empty queue");
`endif

endmodule

@@ design/alsm_front.sv @@
// Front end: classifies each character and stamps it with its line and column.
module alsm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_char_in,
    input  logic                   i_full,
    output logic                   o_wr,
    output alsm_pkg::t_front_beat  o_beat
);
    import alsm_pkg::*;

    logic [LINE_BITS-1:0]   r_line;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [COLUMN_BITS-1:0] n_col;
    logic                   w_acc;
    t_char_class            w_cls;

    assign w_acc = i_push && !i_full;
    assign o_wr  = w_acc;

    always_comb begin
        if (i_char_in == CH_NL) begin
            w_cls = CC_NL;
        end else if (i_char_in == CH_SEMI) begin
            w_cls = CC_SEMI;
        end else if (i_char_in == CH_SPACE || i_char_in == CH_TAB ||
                     i_char_in == CH_CR || i_char_in == CH_COMMA) begin
            w_cls = CC_WS;
        end else if (i_char_in == CH_UP_R) begin
            w_cls = CC_R;
        end else if (i_char_in == CH_AT) begin
            w_cls = CC_AT;
        end else if (i_char_in == CH_HASH) begin
            w_cls = CC_HASH;
        end else if (i_char_in == CH_UNDER) begin
            w_cls = CC_UNDER;
        end else if (i_char_in == CH_ZERO) begin
            w_cls = CC_ZERO;
        end else if (i_char_in > CH_ZERO && i_char_in <= CH_NINE) begin
            w_cls = CC_DIGIT;
        end else if (i_char_in == CH_LOW_X) begin
            w_cls = CC_X;
        end else if ((i_char_in >= CH_UP_A && i_char_in <= CH_UP_F) ||
                     (i_char_in >= CH_LOW_A && i_char_in <= CH_LOW_F)) begin
            w_cls = CC_HEX;
        end else if ((i_char_in >= CH_UP_A && i_char_in <= CH_UP_Z) ||
                     (i_char_in >= CH_LOW_A && i_char_in <= CH_LOW_Z)) begin
            w_cls = CC_ALPHA;
        end else begin
            w_cls = CC_UNK;
        end
    end

    always_comb begin
        o_beat.cls  = w_cls;
        o_beat.line = f_clip(32'(r_line));
        o_beat.col  = f_clip(32'(r_col));
    end

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (w_acc) begin
            if (w_cls == CC_NL) begin
                n_line = (r_line == '1) ? r_line : r_line + 1'b1;
                n_col  = '0;
            end else begin
                n_col  = (r_col == '1) ? r_col : r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_col  <= '0;
        end else begin
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

@@ design/alsm_queue.sv @@
// Two-entry queue of classified beats between front and back.
module alsm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  alsm_pkg::t_front_beat  i_data,
    output logic                   o_full,
    input  logic                   i_rd,
    output alsm_pkg::t_front_beat  o_data,
    output logic                   o_empty
);
    import alsm_pkg::*;

    t_front_beat r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_wr;
    logic        w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

endmodule

@@ design/alsm_back.sv @@
// Back end: lexer state machine and two-entry result queue.
module alsm_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  alsm_pkg::t_front_beat  i_beat,
    output logic                   o_take,
    output logic                   o_empty,
    input  logic                   i_pop,
    output alsm_pkg::t_result      o_result
);
    import alsm_pkg::*;

    t_lex_state  r_state;
    t_lex_state  n_state;
    t_err_code   w_err;
    logic        w_start;
    t_result     w_res;
    t_result     r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_take;
    logic        w_pop;

    assign w_take  = i_valid && (r_cnt != 2'd2);
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_take  = w_take;
    assign o_empty = (r_cnt == 2'd0);
    assign o_result = r_q[r_rd_ptr];

    assign w_start = (r_state == LS_NIL) || (r_state == LS_SEP) || (r_state > LS_ADR);

    // next state; w_err non-zero forces the error state
    always_comb begin
        n_state = r_state;
        w_err   = ER_NONE;
        if (i_beat.cls == CC_NL) begin
            n_state = LS_NIL;
        end else if (r_state == LS_CMT || r_state == LS_ERR) begin
            n_state = r_state;
        end else if (i_beat.cls == CC_SEMI) begin
            n_state = LS_CMT;
        end else if (r_state == LS_ZER && i_beat.cls == CC_X) begin
            n_state = LS_ADT;
        end else begin
            case (i_beat.cls)
                CC_WS: begin
                    if (r_state == LS_RGT) w_err = ER_IDN;
                    else if (r_state == LS_IMT || r_state == LS_ZER) w_err = ER_IMM;
                    else if (r_state == LS_LBT) w_err = ER_LBL;
                    else if (r_state == LS_ADT) w_err = ER_ADR;
                    else n_state = LS_NIL;
                end
                CC_R: begin
                    if (w_start) n_state = LS_RGT;
                    else if (r_state == LS_RGT || r_state == LS_REG) n_state = LS_IDN;
                    else if (r_state == LS_ADT || r_state == LS_ADR) w_err = ER_ADR;
                    else if (r_state == LS_IMT || r_state == LS_IMM) w_err = ER_IMM;
                    else if (r_state == LS_ZER) w_err = ER_IDN;
                end
                CC_AT, CC_HASH: begin
                    if (w_start) begin
                        n_state = (i_beat.cls == CC_AT) ? LS_LBT : LS_IMT;
                    end else if (r_state == LS_IDN || r_state == LS_RGT ||
                                 r_state == LS_REG || r_state == LS_ZER) begin
                        w_err = ER_IDN;
                    end else if (r_state == LS_IMT || r_state == LS_IMM) begin
                        w_err = ER_IMM;
                    end else if (r_state == LS_LBL || r_state == LS_LBT) begin
                        w_err = ER_LBL;
                    end else begin
                        w_err = ER_ADR;
                    end
                end
                CC_UNDER: begin
                    if (w_start || r_state == LS_IDN || r_state == LS_RGT ||
                        r_state == LS_REG) begin
                        n_state = LS_IDN;
                    end else if (r_state == LS_ZER) begin
                        w_err = ER_IDN;
                    end else if (r_state == LS_IMT || r_state == LS_IMM) begin
                        w_err = ER_IMM;
                    end else if (r_state == LS_LBL || r_state == LS_LBT) begin
                        n_state = LS_LBL;
                    end else begin
                        w_err = ER_ADR;
                    end
                end
                CC_ZERO, CC_DIGIT: begin
                    if (w_start) begin
                        if (i_beat.cls == CC_ZERO) n_state = LS_ZER;
                        else w_err = ER_IDN;
                    end else if (r_state == LS_IDN) begin
                        n_state = LS_IDN;
                    end else if (r_state == LS_RGT || r_state == LS_REG) begin
                        n_state = LS_REG;
                    end else if (r_state == LS_IMT || r_state == LS_IMM) begin
                        n_state = LS_IMM;
                    end else if (r_state == LS_LBT || r_state == LS_LBL) begin
                        n_state = LS_LBL;
                    end else if (r_state == LS_ZER) begin
                        w_err = ER_IMM;
                    end else begin
                        n_state = LS_ADR;
                    end
                end
                CC_X, CC_HEX, CC_ALPHA: begin
                    if (w_start || r_state == LS_IDN || r_state == LS_RGT ||
                        r_state == LS_REG) begin
                        n_state = LS_IDN;
                    end else if (r_state == LS_IMT || r_state == LS_IMM) begin
                        w_err = ER_IMM;
                    end else if (r_state == LS_LBT || r_state == LS_LBL) begin
                        n_state = LS_LBL;
                    end else if (r_state == LS_ZER) begin
                        w_err = ER_IDN;
                    end else if (i_beat.cls == CC_HEX) begin
                        n_state = LS_ADR;
                    end else begin
                        w_err = ER_ADR;
                    end
                end
                default: begin
                    w_err = ER_UNK;
                end
            endcase
            if (w_err != ER_NONE) begin
                n_state = LS_ERR;
            end
        end
    end

    always_comb begin
        w_res.state = n_state;
        w_res.err   = w_err;
        w_res.line  = i_beat.line;
        w_res.col   = i_beat.col;
    end

    always_comb begin
        case ({w_take, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_q[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= LS_NIL;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_take) begin
                r_state  <= n_state;
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

endmodule

@@ test/tb.sv @@
// Testbench for assembly_lexer_state_machine_core: token streams and noise.
`timescale 1ns / 100ps

module tb;
    import alsm_pkg::*;

    localparam int WDOG_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 16;
    localparam int MAX_REPORTS = 100;
    localparam int RAND_CHARS  = 1620;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_in = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_lex_state;
    logic [2:0]  o_error_code;
    logic [15:0] o_line_number;
    logic [15:0] o_column_number;

    logic [7:0] src_text [$];
    t_result    due_lex [$];

    t_lex_state             lex_now = LS_NIL;
    logic [LINE_BITS-1:0]   line_at = '0;
    logic [COLUMN_BITS-1:0] col_at  = '0;

    logic        in_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    logic [15:0] pop_pat = '1;
    logic [3:0]  pop_idx = '0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    assembly_lexer_state_machine_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_char_in       (i_char_in),
        .empty           (empty),
        .pop             (pop),
        .o_lex_state     (o_lex_state),
        .o_error_code    (o_error_code),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // next lexer state, raised error and position of one character
    function automatic t_result lex_step(input logic [7:0] c);
        t_result    r;
        t_lex_state s;
        t_lex_state nxt;
        t_err_code  err;
        logic       ws, digit, alpha, hex, start;
        s     = lex_now;
        nxt   = s;
        err   = ER_NONE;
        ws    = (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_COMMA);
        digit = (c >= CH_ZERO && c <= CH_NINE);
        alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
        hex   = (c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LOW_A && c <= CH_LOW_F);
        start = (s == LS_NIL || s == LS_SEP || s > LS_ADR);

        if (c == CH_NL) begin
            nxt = LS_NIL;
        end else if (s == LS_CMT || s == LS_ERR) begin
            nxt = s;
        end else if (c == CH_SEMI) begin
            nxt = LS_CMT;
        end else if (s == LS_ZER && c == CH_LOW_X) begin
            nxt = LS_ADT;
        end else if (ws) begin
            case (s)
                LS_RGT:         err = ER_IDN;
                LS_IMT, LS_ZER: err = ER_IMM;
                LS_LBT:         err = ER_LBL;
                LS_ADT:         err = ER_ADR;
                default:        nxt = LS_NIL;
            endcase
        end else if (c == CH_UP_R) begin
            if (start) begin
                nxt = LS_RGT;
            end else begin
                case (s)
                    LS_RGT, LS_REG: nxt = LS_IDN;
                    LS_ADT, LS_ADR: err = ER_ADR;
                    LS_IMT, LS_IMM: err = ER_IMM;
                    LS_ZER:         err = ER_IDN;
                    default:        nxt = s;
                endcase
            end
        end else if (c == CH_AT || c == CH_HASH) begin
            if (start) begin
                nxt = (c == CH_AT) ? LS_LBT : LS_IMT;
            end else begin
                case (s)
                    LS_IDN, LS_RGT, LS_REG, LS_ZER: err = ER_IDN;
                    LS_IMT, LS_IMM:                 err = ER_IMM;
                    LS_LBL, LS_LBT:                 err = ER_LBL;
                    default:                        err = ER_ADR;
                endcase
            end
        end else if (c == CH_UNDER) begin
            if (start) begin
                nxt = LS_IDN;
            end else begin
                case (s)
                    LS_IDN, LS_RGT, LS_REG: nxt = LS_IDN;
                    LS_ZER:                 err = ER_IDN;
                    LS_IMT, LS_IMM:         err = ER_IMM;
                    LS_LBL, LS_LBT:         nxt = LS_LBL;
                    default:                err = ER_ADR;
                endcase
            end
        end else if (digit) begin
            if (start) begin
                if (c == CH_ZERO) nxt = LS_ZER;
                else err = ER_IDN;
            end else begin
                case (s)
                    LS_IDN:         nxt = LS_IDN;
                    LS_RGT, LS_REG: nxt = LS_REG;
                    LS_IMT, LS_IMM: nxt = LS_IMM;
                    LS_LBT, LS_LBL: nxt = LS_LBL;
                    LS_ZER:         err = ER_IMM;
                    default:        nxt = LS_ADR;
                endcase
            end
        end else if (alpha) begin
            if (start) begin
                nxt = LS_IDN;
            end else begin
                case (s)
                    LS_IDN, LS_RGT, LS_REG: nxt = LS_IDN;
                    LS_IMT, LS_IMM:         err = ER_IMM;
                    LS_LBT, LS_LBL:         nxt = LS_LBL;
                    LS_ZER:                 err = ER_IDN;
                    default: begin
                        if (hex) nxt = LS_ADR;
                        else err = ER_ADR;
                    end
                endcase
            end
        end else begin
            err = ER_UNK;
        end

        if (err != ER_NONE) nxt = LS_ERR;

        r.state = nxt;
        r.err   = err;
        r.line  = line_at;
        r.col   = col_at;

        lex_now = nxt;
        if (c == CH_NL) begin
            if (line_at != '1) line_at = line_at + 1'b1;
            col_at = '0;
        end else if (col_at != '1) begin
            col_at = col_at + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rnd_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rnd_letter();
        if ($urandom_range(0, 1) == 0) return 8'(CH_UP_A + $urandom_range(0, 25));
        return 8'(CH_LOW_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rnd_hex();
        case ($urandom_range(0, 2))
            0:       return rnd_digit();
            1:       return 8'(CH_UP_A + $urandom_range(0, 5));
            default: return 8'(CH_LOW_A + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] rnd_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_COMMA;
        endcase
    endfunction

    function automatic logic [7:0] rnd_body();
        case ($urandom_range(0, 4))
            0:       return rnd_digit();
            1:       return CH_UNDER;
            2:       return CH_UP_R;
            default: return rnd_letter();
        endcase
    endfunction

    // characters that hit a distinct branch from any state
    function automatic logic [7:0] rnd_probe();
        case ($urandom_range(0, 12))
            0:       return CH_UP_R;
            1:       return CH_AT;
            2:       return CH_HASH;
            3:       return CH_UNDER;
            4:       return CH_ZERO;
            5:       return rnd_digit();
            6:       return CH_LOW_X;
            7:       return rnd_hex();
            8:       return rnd_letter();
            9:       return rnd_ws();
            10:      return CH_SEMI;
            11:      return CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_token();
        int n;
        logic [7:0] c;
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 9))
            0: begin
                src_text.push_back(rnd_letter());
                repeat (n) src_text.push_back(rnd_body());
            end
            1: begin
                src_text.push_back(CH_UP_R);
                repeat (n) src_text.push_back(rnd_digit());
            end
            2: begin
                src_text.push_back(CH_HASH);
                repeat (n) src_text.push_back(rnd_digit());
            end
            3: begin
                src_text.push_back(CH_AT);
                repeat (n) src_text.push_back(rnd_body());
            end
            4: begin
                src_text.push_back(CH_ZERO);
                src_text.push_back(CH_LOW_X);
                repeat (n) src_text.push_back(rnd_hex());
            end
            5: src_text.push_back(CH_ZERO);
            6: begin
                src_text.push_back(CH_SEMI);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    src_text.push_back((c == CH_NL) ? CH_SPACE : c);
                end
            end
            7: src_text.push_back(8'($urandom_range(0, 255)));
            default: begin
                // valid prefix, then anything
                case ($urandom_range(0, 8))
                    0: src_text.push_back(CH_UP_R);
                    1: begin src_text.push_back(CH_UP_R); src_text.push_back(rnd_digit()); end
                    2: src_text.push_back(CH_HASH);
                    3: begin src_text.push_back(CH_HASH); src_text.push_back(rnd_digit()); end
                    4: src_text.push_back(CH_AT);
                    5: begin src_text.push_back(CH_AT); src_text.push_back(rnd_body()); end
                    6: src_text.push_back(CH_ZERO);
                    7: begin src_text.push_back(CH_ZERO); src_text.push_back(CH_LOW_X); end
                    default: begin
                        src_text.push_back(CH_ZERO);
                        src_text.push_back(CH_LOW_X);
                        src_text.push_back(rnd_hex());
                    end
                endcase
                src_text.push_back(rnd_probe());
            end
        endcase
        if ($urandom_range(0, 4) == 0) src_text.push_back(CH_NL);
        else src_text.push_back(rnd_ws());
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender: bursts with gaps, one beat offered at a time
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || in_taken) begin
            if (gap_left != 0 || src_text.size() == 0) begin
                push <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                push      <= 1'b1;
                i_char_in <= src_text.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: rotating pop pattern, reloaded each time its index wraps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= pop_pat[pop_idx];
            pop_idx = pop_idx + 1'b1;
            if (pop_idx == 4'd0) begin
                case ($urandom_range(0, 3))
                    0:       pop_pat = '1;
                    1:       pop_pat = 16'($urandom);
                    2:       pop_pat = 16'($urandom) | 16'($urandom);
                    default: pop_pat = 16'($urandom) & 16'($urandom);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        in_taken <= i_rst_n && push && !full;
        if (i_rst_n) begin
            if (push && !full) due_lex.push_back(lex_step(i_char_in));
            if (pop && !empty) begin
                if (due_lex.size() == 0) begin
                    if (mismatches < MAX_REPORTS) $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    want = due_lex.pop_front();
                    check_field("lex_state", 16'(want.state), 16'(o_lex_state));
                    check_field("error_code", 16'(want.err), 16'(o_error_code));
                    check_field("line_number", want.line, o_line_number);
                    check_field("column_number", want.col, o_column_number);
                end
            end
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] intro [25];
        int         base;
        intro = '{8'h00, 8'hFF, CH_NL, CH_UP_R, "7", CH_SPACE, CH_AT, "L", CH_UNDER, CH_TAB,
                  CH_HASH, "1", CH_CR, CH_ZERO, CH_LOW_X, CH_UP_A, "f", CH_COMMA, CH_SEMI,
                  "Q", CH_NL, CH_ZERO, CH_LOW_X, "G", 8'h80};
        foreach (intro[i]) src_text.push_back(intro[i]);

        base = src_text.size();
        while (src_text.size() < base + RAND_CHARS) add_token();
        src_text.push_back(CH_NL);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (src_text.size() != 0 || push) @(posedge i_clk);
        while (due_lex.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
